// File: src/dbp_pkg.sv
package dbp_pkg;

   // Elaboration defaults
   localparam int unsigned MAX_DIM_DEF = 4096;

   // Field widths
   localparam int PIX_W   = 12;
   localparam int DEPTH_W = 16;
   localparam int CFG_W   = 16;
   localparam int COORD_W = 32;
   localparam int PROD_W  = 32;   // |diff| * depth
   localparam int FRAC_W  = 8;    // fractional bits of x and y
   localparam int NUM_W   = PROD_W + FRAC_W;

   // One quotient bit per divider stage
   localparam int DIV_STAGES = COORD_W;

   // Register file
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_COL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_ROW = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_COL  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_ROW  = CSR_IDX_W'(3);

   localparam logic [CFG_W-1:0] CENTER_RESET = CFG_W'(0);
   localparam logic [CFG_W-1:0] FOCAL_RESET  = CFG_W'(16);

   // Camera intrinsics as seen by the datapath; focal values are never zero
   typedef struct packed {
      logic [CFG_W-1:0] center_col;
      logic [CFG_W-1:0] center_row;
      logic [CFG_W-1:0] focal_col;
      logic [CFG_W-1:0] focal_row;
   } cfg_type;

   // Per-axis divider state: sh holds the remaining dividend bits on top and
   // the quotient bits shifted in from below
   typedef struct packed {
      logic               neg;
      logic               ovf;
      logic [CFG_W-1:0]   rem;
      logic [COORD_W-1:0] sh;
   } axis_type;

   typedef struct packed {
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      logic [DEPTH_W-1:0] depth;
      axis_type           ax_x;
      axis_type           ax_y;
   } item_type;

endpackage

// File: src/dbp_front.sv
module dbp_front #(
   parameter int unsigned MAX_DIM = dbp_pkg::MAX_DIM_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dbp_pkg::PIX_W-1:0]   in_col,
   input  logic [dbp_pkg::PIX_W-1:0]   in_row,
   input  logic [dbp_pkg::DEPTH_W-1:0] in_depth,
   input  dbp_pkg::cfg_type            cfg,
   output logic                        out_valid,
   output dbp_pkg::item_type           out_item,
   input  logic                        nxt_ld
);
   import dbp_pkg::*;

   localparam logic [16:0] MaxDim = 17'(MAX_DIM);

   // stage 1: offset from principal point, split into sign and magnitude
   logic               s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]   s1_col_ff, s1_row_ff;
   logic [DEPTH_W-1:0] s1_depth_ff;
   logic [CFG_W-1:0]   s1_mag_x_ff, s1_mag_x_in, s1_mag_y_ff, s1_mag_y_in;
   logic               s1_neg_x_ff, s1_neg_y_ff;
   logic [16:0]        diff_x, diff_y;
   logic               s1_ld;

   // stage 2: product
   logic               s2_valid_ff;
   logic [PIX_W-1:0]   s2_col_ff, s2_row_ff;
   logic [DEPTH_W-1:0] s2_depth_ff;
   logic [PROD_W-1:0]  s2_prod_x_ff, s2_prod_y_ff;
   logic               s2_neg_x_ff, s2_neg_y_ff;
   logic               s2_ld;

   // stage 3: rounding bias, overflow check, divider seed
   logic               s3_valid_ff;
   item_type           s3_item_ff, s3_item_in;
   logic [NUM_W-1:0]   num_x, num_y;
   logic               s3_ld;

   assign s3_ld    = !s3_valid_ff || nxt_ld;
   assign s2_ld    = !s2_valid_ff || s3_ld;
   assign s1_ld    = !s1_valid_ff || s2_ld;
   assign in_ready = s1_ld;

   // zero depth and pixels outside the image are dropped here
   assign s1_valid_in = in_valid && (in_depth != '0)
                        && ({5'b0, in_col} < MaxDim) && ({5'b0, in_row} < MaxDim);

   assign diff_x = {1'b0, in_col, 4'b0} - {1'b0, cfg.center_col};
   assign diff_y = {1'b0, in_row, 4'b0} - {1'b0, cfg.center_row};
   assign s1_mag_x_in = diff_x[16] ? CFG_W'(-diff_x) : diff_x[CFG_W-1:0];
   assign s1_mag_y_in = diff_y[16] ? CFG_W'(-diff_y) : diff_y[CFG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ld) s1_valid_ff <= s1_valid_in;
         if (s2_ld) s2_valid_ff <= s1_valid_ff;
         if (s3_ld) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ld) begin
         s1_col_ff   <= in_col;
         s1_row_ff   <= in_row;
         s1_depth_ff <= in_depth;
         s1_mag_x_ff <= s1_mag_x_in;
         s1_mag_y_ff <= s1_mag_y_in;
         s1_neg_x_ff <= diff_x[16];
         s1_neg_y_ff <= diff_y[16];
      end
      if (s2_ld) begin
         s2_col_ff    <= s1_col_ff;
         s2_row_ff    <= s1_row_ff;
         s2_depth_ff  <= s1_depth_ff;
         s2_prod_x_ff <= s1_mag_x_ff * s1_depth_ff;
         s2_prod_y_ff <= s1_mag_y_ff * s1_depth_ff;
         s2_neg_x_ff  <= s1_neg_x_ff;
         s2_neg_y_ff  <= s1_neg_y_ff;
      end
      if (s3_ld) s3_item_ff <= s3_item_in;
   end

   // magnitude * 256 + focal/2, the numerator of round-half-away division
   assign num_x = {s2_prod_x_ff, FRAC_W'(0)} + NUM_W'(cfg.focal_col >> 1);
   assign num_y = {s2_prod_y_ff, FRAC_W'(0)} + NUM_W'(cfg.focal_row >> 1);

   // quotient needs more than 32 bits when the top byte already reaches focal;
   // the seed remainder is cleared then so the divider stays in range
   always_comb begin
      s3_item_in.col       = s2_col_ff;
      s3_item_in.row       = s2_row_ff;
      s3_item_in.depth     = s2_depth_ff;
      s3_item_in.ax_x.neg  = s2_neg_x_ff;
      s3_item_in.ax_x.ovf  = {8'b0, num_x[NUM_W-1:COORD_W]} >= cfg.focal_col;
      s3_item_in.ax_x.rem  = s3_item_in.ax_x.ovf ? '0 : {8'b0, num_x[NUM_W-1:COORD_W]};
      s3_item_in.ax_x.sh   = num_x[COORD_W-1:0];
      s3_item_in.ax_y.neg  = s2_neg_y_ff;
      s3_item_in.ax_y.ovf  = {8'b0, num_y[NUM_W-1:COORD_W]} >= cfg.focal_row;
      s3_item_in.ax_y.rem  = s3_item_in.ax_y.ovf ? '0 : {8'b0, num_y[NUM_W-1:COORD_W]};
      s3_item_in.ax_y.sh   = num_y[COORD_W-1:0];
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// File: src/dbp_div_stage.sv
module dbp_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  dbp_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  dbp_pkg::item_type in_item,
   output logic              ld,
   output logic              out_valid,
   output dbp_pkg::item_type out_item,
   input  logic              nxt_ld
);
   import dbp_pkg::*;

   logic     valid_ff;
   item_type item_ff, item_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic axis_type div_step(axis_type a, logic [CFG_W-1:0] f);
      logic [CFG_W:0] trial;
      logic [CFG_W:0] diff;
      logic           ge;
      axis_type       r;
      trial = {a.rem, a.sh[COORD_W-1]};
      diff  = trial - {1'b0, f};
      ge    = trial >= {1'b0, f};
      r     = a;
      r.rem = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      r.sh  = {a.sh[COORD_W-2:0], ge};
      return r;
   endfunction

   assign ld = !valid_ff || nxt_ld;

   always_comb begin
      item_in      = in_item;
      item_in.ax_x = div_step(in_item.ax_x, cfg.focal_col);
      item_in.ax_y = div_step(in_item.ax_y, cfg.focal_row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ld) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: src/dbp_back.sv
module dbp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  dbp_pkg::item_type           in_item,
   output logic                        ld,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [dbp_pkg::COORD_W-1:0] out_x,
   output logic [dbp_pkg::COORD_W-1:0] out_y,
   output logic [dbp_pkg::DEPTH_W-1:0] out_z,
   output logic [dbp_pkg::PIX_W-1:0]   out_col,
   output logic [dbp_pkg::PIX_W-1:0]   out_row,
   output logic                        out_clipped
);
   import dbp_pkg::*;

   logic               valid_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [DEPTH_W-1:0] z_ff;
   logic [PIX_W-1:0]   col_ff, row_ff;
   logic               clipped_ff;
   logic [COORD_W:0]   res_x, res_y;

   // {saturated, value}: apply sign to the quotient and clamp to 32 bits
   function automatic logic [COORD_W:0] sign_sat(axis_type a);
      logic               sat;
      logic [COORD_W-1:0] val;
      if (a.neg) begin
         sat = a.ovf || (a.sh[COORD_W-1] && (a.sh[COORD_W-2:0] != '0));
         val = sat ? {1'b1, {(COORD_W-1){1'b0}}} : -a.sh;
      end else begin
         sat = a.ovf || a.sh[COORD_W-1];
         val = sat ? {1'b0, {(COORD_W-1){1'b1}}} : a.sh;
      end
      return {sat, val};
   endfunction

   assign res_x = sign_sat(in_item.ax_x);
   assign res_y = sign_sat(in_item.ax_y);

   assign ld = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ld) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         x_ff       <= res_x[COORD_W-1:0];
         y_ff       <= res_y[COORD_W-1:0];
         z_ff       <= in_item.depth;
         col_ff     <= in_item.col;
         row_ff     <= in_item.row;
         clipped_ff <= res_x[COORD_W] || res_y[COORD_W];
      end
   end

   assign out_valid   = valid_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_z       = z_ff;
   assign out_col     = col_ff;
   assign out_row     = row_ff;
   assign out_clipped = clipped_ff;

endmodule

// File: src/depth_pixel_backprojection.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  col, row, depth_mm
// rsp_      out        rsp_valid/rsp_ready  point_x, point_y, point_z, pixel_col,
//                                           pixel_row, clipped
// csr_      in         csr_valid/csr_ready  index, wdata (16-bit registers)
//
// One item per cycle sustained while rsp_ready stays high; 3 front stages, one divider
// stage per quotient bit, 1 output stage. The bit-serial divider sets depth.
// Reset clears all valid bits and loads the register reset values.
// Each stage loads when empty or when its item moves on, so bubbles close up
// under a stalled rsp_ready and req_ready stays high while any slot is free.
// csr_ready is always high.
module depth_pixel_backprojection #(
   parameter int unsigned MAX_DIM = dbp_pkg::MAX_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dbp_pkg::PIX_W-1:0]     req_col,
   input  logic [dbp_pkg::PIX_W-1:0]     req_row,
   input  logic [dbp_pkg::DEPTH_W-1:0]   req_depth_mm,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [dbp_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [dbp_pkg::COORD_W-1:0] rsp_point_y,
   output logic [dbp_pkg::DEPTH_W-1:0]   rsp_point_z,
   output logic [dbp_pkg::PIX_W-1:0]     rsp_pixel_col,
   output logic [dbp_pkg::PIX_W-1:0]     rsp_pixel_row,
   output logic                          rsp_clipped,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dbp_pkg::CFG_W-1:0]     csr_wdata
);
   import dbp_pkg::*;

   localparam logic [16:0] MaxDim = 17'(MAX_DIM);

   // ---------------------------------------------------------------------
   // Camera registers, Q12.4 pixels
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] center_col_ff, center_row_ff, focal_col_ff, focal_row_ff;
   logic             csr_wr;
   cfg_type          cfg;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= CENTER_RESET;
         center_row_ff <= CENTER_RESET;
         focal_col_ff  <= FOCAL_RESET;
         focal_row_ff  <= FOCAL_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_CENTER_COL: center_col_ff <= csr_wdata;
            REG_CENTER_ROW: center_row_ff <= csr_wdata;
            REG_FOCAL_COL:  focal_col_ff  <= csr_wdata;
            REG_FOCAL_ROW:  focal_row_ff  <= csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // a zero focal length behaves as 1/16 pixel
   always_comb begin
      cfg.center_col = center_col_ff;
      cfg.center_row = center_row_ff;
      cfg.focal_col  = (focal_col_ff == '0) ? CFG_W'(1) : focal_col_ff;
      cfg.focal_row  = (focal_row_ff == '0) ? CFG_W'(1) : focal_row_ff;
   end

   // ---------------------------------------------------------------------
   // Pipeline: front (offset, multiply, round bias) -> divider -> sign/clamp
   // stage_* index i is the input side of divider stage i
   // ---------------------------------------------------------------------
   logic     stage_valid [0:DIV_STAGES];
   item_type stage_item  [0:DIV_STAGES];
   logic     stage_ld    [0:DIV_STAGES];

   dbp_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_col    (req_col),
      .in_row    (req_row),
      .in_depth  (req_depth_mm),
      .cfg       (cfg),
      .out_valid (stage_valid[0]),
      .out_item  (stage_item[0]),
      .nxt_ld    (stage_ld[0])
   );

   // one quotient bit per stage, MSB first
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      dbp_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .in_valid  (stage_valid[i]),
         .in_item   (stage_item[i]),
         .ld        (stage_ld[i]),
         .out_valid (stage_valid[i+1]),
         .out_item  (stage_item[i+1]),
         .nxt_ld    (stage_ld[i+1])
      );
   end

   logic [COORD_W-1:0] out_x, out_y;

   dbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid[DIV_STAGES]),
      .in_item     (stage_item[DIV_STAGES]),
      .ld          (stage_ld[DIV_STAGES]),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_x       (out_x),
      .out_y       (out_y),
      .out_z       (rsp_point_z),
      .out_col     (rsp_pixel_col),
      .out_row     (rsp_pixel_row),
      .out_clipped (rsp_clipped)
   );

   assign rsp_point_x = out_x;
   assign rsp_point_y = out_y;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a free output lets the whole pipeline move, so input is never blocked while rsp_ready is high
   a_ready_path: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   a_no_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_z != '0))
      else $error("result for a zero depth");

   a_in_image: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({5'b0, rsp_pixel_col} < MaxDim) && ({5'b0, rsp_pixel_row} < MaxDim)))
      else $error("result for a pixel outside the image");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         ((rsp_point_x == 32'sh7FFFFFFF) || (rsp_point_x == 32'sh80000000) ||
          (rsp_point_y == 32'sh7FFFFFFF) || (rsp_point_y == 32'sh80000000)))
      else $error("clipped flag without a saturated coordinate");

   a_focal_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cfg.focal_col != '0) && (cfg.focal_row != '0))
      else $error("zero divisor reached the divider");

endmodule

// File: sim/testbench.sv
module testbench;
   import dbp_pkg::*;

   // One back-projected point as it leaves the result channel
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [DEPTH_W-1:0]        z;
      logic [PIX_W-1:0]          col;
      logic [PIX_W-1:0]          row;
      logic                      clipped;
   } point_type;

   class point_scoreboard;
      localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
      localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
      localparam int REPORT_CAP = 100;

      logic [CFG_W-1:0] center_col, center_row, focal_col, focal_row;
      point_type        pending_points[$];
      int unsigned      mismatches;
      int unsigned      reports;

      function new();
         center_col = CENTER_RESET;
         center_row = CENTER_RESET;
         focal_col  = FOCAL_RESET;
         focal_row  = FOCAL_RESET;
         mismatches = 0;
         reports    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_CENTER_COL: center_col = data;
            REG_CENTER_ROW: center_row = data;
            REG_FOCAL_COL:  focal_col  = data;
            REG_FOCAL_ROW:  focal_row  = data;
            default: ;
         endcase
      endfunction

      // (pix*16 - center) * depth * 256 / focal, nearest with ties away from
      // zero, then clamped to 32 bits signed
      function logic [COORD_W-1:0] back_project(logic [PIX_W-1:0] pix,
                                                logic [CFG_W-1:0] ctr,
                                                logic [CFG_W-1:0] foc,
                                                logic [DEPTH_W-1:0] d,
                                                inout bit sat);
         longint          offset, num;
         longint unsigned divisor, mag, quot;
         bit              neg;
         offset  = longint'(pix) * 16 - longint'(ctr);
         num     = offset * longint'(d) * 256;
         divisor = (foc == 0) ? 64'd1 : 64'(foc);
         neg     = num < 0;
         mag     = neg ? -num : num;
         quot    = (mag + divisor / 2) / divisor;
         if (!neg && quot > 64'd2147483647) begin
            sat = 1;
            return COORD_MAX;
         end
         if (neg && quot > 64'd2147483648) begin
            sat = 1;
            return COORD_MIN;
         end
         return neg ? COORD_W'(-quot) : COORD_W'(quot);
      endfunction

      function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                               logic [DEPTH_W-1:0] depth);
         point_type p;
         bit        sat;
         sat = 0;
         if (depth == 0) return;
         if (int'(col) >= int'(MAX_DIM_DEF) || int'(row) >= int'(MAX_DIM_DEF)) return;
         p.x       = back_project(col, center_col, focal_col, depth, sat);
         p.y       = back_project(row, center_row, focal_row, depth, sat);
         p.z       = depth;
         p.col     = col;
         p.row     = row;
         p.clipped = sat;
         pending_points.insert(pending_points.size(), p);
      endfunction

      function bit differs(string field, longint want, longint got);
         if (want == got) return 0;
         if (reports < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         reports++;
         return 1;
      endfunction

      function void check_point(point_type got);
         point_type want;
         bit        bad;
         if (pending_points.size() == 0) begin
            mismatches++;
            if (reports < REPORT_CAP)
               $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d col=%0d row=%0d clipped=%0d",
                        $time, got.x, got.y, got.z, got.col, got.row, got.clipped);
            reports++;
            return;
         end
         want = pending_points.pop_front();
         bad  = 0;
         bad |= differs("point_x", want.x, got.x);
         bad |= differs("point_y", want.y, got.y);
         bad |= differs("point_z", want.z, got.z);
         bad |= differs("pixel_col", want.col, got.col);
         bad |= differs("pixel_row", want.row, got.row);
         bad |= differs("clipped", want.clipped, got.clipped);
         if (bad) mismatches++;
      endfunction

      function int unsigned outstanding();
         return pending_points.size();
      endfunction
   endclass

   // pipeline depth is 36; a little margin so zero-depth items flush too
   localparam int DRAIN_CYCLES = 44;
   // cycles with no handshake at all before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 108;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNUSED = REG_FOCAL_ROW + 1;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_INDEX   = {CSR_IDX_W{1'b1}};
   localparam logic [CFG_W-1:0]     CFG_MAX          = {CFG_W{1'b1}};
   localparam logic [PIX_W-1:0]     PIX_MAX          = {PIX_W{1'b1}};
   localparam logic [DEPTH_W-1:0]   DEPTH_MAX        = {DEPTH_W{1'b1}};

   logic clock = 0;
   logic reset = 1;

   logic                  req_valid = 0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_col = '0;
   logic [PIX_W-1:0]      req_row = '0;
   logic [DEPTH_W-1:0]    req_depth_mm = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   logic signed [COORD_W-1:0] rsp_point_x;
   logic signed [COORD_W-1:0] rsp_point_y;
   logic [DEPTH_W-1:0]        rsp_point_z;
   logic [PIX_W-1:0]          rsp_pixel_col;
   logic [PIX_W-1:0]          rsp_pixel_row;
   logic                      rsp_clipped;

   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // percent of cycles in which each side holds back
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles   = 0;

   point_scoreboard sb = new();

   depth_pixel_backprojection dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_depth_mm  (req_depth_mm),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_pixel_row (rsp_pixel_row),
      .rsp_clipped   (rsp_clipped),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #2 clock = ~clock;

   // Receiver: back-pressure decided once per cycle at the falling edge
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitors and watchdog, all sampled at the rising edge.
   // Results are checked before the same edge's input is noted; with the
   // pipeline depth they never belong to the same item anyway.
   always @(posedge clock) begin
      point_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.x       = rsp_point_x;
            got.y       = rsp_point_y;
            got.z       = rsp_point_z;
            got.col     = rsp_pixel_col;
            got.row     = rsp_pixel_row;
            got.clipped = rsp_clipped;
            sb.check_point(got);
         end
         if (req_valid && req_ready) sb.note_pixel(req_col, req_row, req_depth_mm);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);

         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Present one pixel and hold it until the block takes it. Valid stays
   // high into the next item unless the sender decides to idle first.
   task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                             input logic [DEPTH_W-1:0] depth);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid    = 1;
      req_col      = col;
      req_row      = row;
      req_depth_mm = depth;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait for the pipe to empty. Zero-depth items leave
   // no expectation behind, so give them the full depth to flush out.
   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_camera(input logic [CFG_W-1:0] cc, input logic [CFG_W-1:0] cr,
                             input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] fr);
      write_csr(REG_CENTER_COL, cc);
      write_csr(REG_CENTER_ROW, cr);
      write_csr(REG_FOCAL_COL, fc);
      write_csr(REG_FOCAL_ROW, fr);
   endtask

   function automatic logic [CFG_W-1:0] pick_center();
      case ($urandom_range(3))
         0: return '0;
         1: return CFG_MAX;
         2: return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(3000, 1000) * 16 + $urandom_range(15));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_focal();
      case ($urandom_range(4))
         0: return CFG_W'($urandom_range(1));   // zero acts as one
         1: return CFG_MAX;
         2: return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(1200, 200) * 16 + $urandom_range(15));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return PIX_MAX;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Mostly valid depths; a few zeros that must vanish
   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(11))
         0: return '0;
         1: return DEPTH_MAX;
         2, 3, 4: return DEPTH_W'($urandom_range(4000, 1));
         default: return DEPTH_W'($urandom);
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: first under the reset intrinsics (center 0, focal 1.0)
      send_idle_pct = 10;
      recv_idle_pct = 66;
      send_pixel('0, '0, '0);                 // zero depth, dropped
      send_pixel('0, '0, DEPTH_W'(1));        // lands on the origin
      send_pixel(PIX_W'(1), PIX_W'(1), DEPTH_W'(1));
      send_pixel(PIX_MAX, PIX_MAX, DEPTH_MAX);  // positive saturation on both axes
      send_pixel(PIX_MAX, '0, DEPTH_W'(1));
      send_pixel('0, PIX_MAX, DEPTH_MAX);
      send_pixel(PIX_W'(2048), PIX_W'(2048), '0);
      settle();

      // Extreme center, smallest and largest focal: negative saturation on x
      set_camera(CFG_MAX, CFG_MAX, CFG_W'(1), CFG_MAX);
      send_pixel('0, '0, DEPTH_MAX);
      send_pixel(PIX_MAX, PIX_MAX, DEPTH_W'(1));
      send_pixel(PIX_MAX, PIX_MAX, DEPTH_MAX);
      send_pixel('0, PIX_MAX, DEPTH_W'(1));
      settle();

      // Half-way quotients round away from zero; a zero focal acts as one
      set_camera(CFG_W'(1), '0, CFG_W'(512), '0);
      send_pixel('0, PIX_W'(1), DEPTH_W'(1));            // x = -0.5 lsb, y through zero focal
      send_pixel(PIX_W'(1), PIX_MAX, DEPTH_W'(1));       // x = +7.5 lsb
      send_pixel('0, '0, '0);
      send_pixel(PIX_W'(3), PIX_W'(3), DEPTH_W'(3));
      settle();

      // Writes to indexes past the register file change nothing
      write_csr(REG_FIRST_UNUSED, CFG_W'($urandom));
      write_csr(REG_LAST_INDEX, CFG_W'($urandom));
      write_csr(CSR_IDX_W'($urandom_range(int'(REG_LAST_INDEX), int'(REG_FIRST_UNUSED))),
                CFG_W'($urandom));
      send_pixel(PIX_W'(1), PIX_MAX, DEPTH_W'(1));
      send_pixel(PIX_MAX, PIX_W'(2), DEPTH_W'(7));
      settle();

      // Random part: two phases per idling mode, fresh intrinsics each phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            1: set_camera(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
            3: set_camera('0, '0, CFG_W'(1), CFG_W'(1));
            default: set_camera(pick_center(), pick_center(), pick_focal(), pick_focal());
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_pixel(pick_pixel(), pick_pixel(), pick_depth());
            // hold the sender off until every pending result has come out once
            if (phase == 2 && n == PHASE_ITEMS / 2) begin
               @(negedge clock);
               req_valid = 0;
               while (sb.outstanding() != 0) @(posedge clock);
            end
         end
         settle();
      end

      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
